// File: src/assert_macros.svh
// Assertion macros shared by the strict base64 decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SB64_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sb64 assertion failed");

// Same-cycle implication.
`define SB64_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sb64 assertion failed");

// Next-cycle implication.
`define SB64_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sb64 assertion failed");

`endif

// File: src/sb64_pkg.sv
// Package: types, constants and alphabet lookup for the strict base64 decoder.
package sb64_pkg;

   localparam int CHAR_W   = 8;
   localparam int SEXTET_W = 6;
   localparam int POS_W    = 2;
   localparam int PADS_W   = 2;

   localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

   localparam logic [SEXTET_W-1:0] SEXTET_LC_BASE = 6'd26;
   localparam logic [SEXTET_W-1:0] SEXTET_DG_BASE = 6'd52;
   localparam logic [SEXTET_W-1:0] SEXTET_PLUS    = 6'd62;
   localparam logic [SEXTET_W-1:0] SEXTET_SLASH   = 6'd63;

   localparam logic [SEXTET_W-1:0] TAIL_MASK_POS2 = 6'h0F;
   localparam logic [SEXTET_W-1:0] TAIL_MASK_POS3 = 6'h03;

   localparam logic [POS_W-1:0]  POS_ZERO  = 2'd0;
   localparam logic [POS_W-1:0]  POS_ONE   = 2'd1;
   localparam logic [POS_W-1:0]  POS_TWO   = 2'd2;
   localparam logic [POS_W-1:0]  POS_THREE = 2'd3;
   localparam logic [PADS_W-1:0] PADS_NONE = 2'd0;
   localparam logic [PADS_W-1:0] PADS_MAX  = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_INVALID     = 2'd1,
      STATUS_MISSING_PAD = 2'd2
   } status_type;

   typedef struct packed {
      logic                is_alpha;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   typedef struct packed {
      logic              emit;
      logic [CHAR_W-1:0] out_byte;
      logic              byte_valid;
      status_type        status;
      logic              done_res;
   } result_type;

   function automatic sextet_type sextet_of(input logic [CHAR_W-1:0] c);
      sextet_type s;
      s.is_alpha = 1'b1;
      s.value    = '0;
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         s.value = SEXTET_W'(c - CHAR_UC_A);
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         s.value = SEXTET_LC_BASE + SEXTET_W'(c - CHAR_LC_A);
      end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
         s.value = SEXTET_DG_BASE + SEXTET_W'(c - CHAR_D0);
      end else if (c == CHAR_PLUS) begin
         s.value = SEXTET_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.value = SEXTET_SLASH;
      end else begin
         s.is_alpha = 1'b0;
      end
      return s;
   endfunction

endpackage

// File: src/sb64_in_stage.sv
// Input register stage: holds one accepted character until the decode stage takes it.
module sb64_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [sb64_pkg::CHAR_W-1:0] req_in_char,
   input  logic                      req_is_final,
   input  logic                      advance,
   output logic                      item_valid,
   output logic [sb64_pkg::CHAR_W-1:0] item_char,
   output logic                      item_final
);

   logic                        valid_ff, valid_in;
   logic [sb64_pkg::CHAR_W-1:0] char_ff;
   logic                        final_ff;

   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? 1'b1 : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!req_stall && req_valid) begin
         char_ff  <= req_in_char;
         final_ff <= req_is_final;
      end
   end

   assign item_valid = valid_ff;
   assign item_char  = char_ff;
   assign item_final = final_ff;

endmodule

// File: src/sb64_decode.sv
// Decode stage: text state, sextet-to-byte assembly and final status.
`include "assert_macros.svh"
module sb64_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [sb64_pkg::CHAR_W-1:0]  in_char,
   input  logic                         is_final,
   output sb64_pkg::result_type         result
);

   logic [sb64_pkg::SEXTET_W-1:0] prev_ff, prev_in;
   logic [sb64_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [sb64_pkg::PADS_W-1:0]   pads_ff, pads_in;
   logic                          seen_ff, seen_in;
   logic                          hard_ff, hard_in;
   logic                          noncanon_ff, noncanon_in;

   sb64_pkg::sextet_type          sx;
   logic                          is_pad;
   logic [sb64_pkg::SEXTET_W-1:0] mask;
   logic [sb64_pkg::CHAR_W-1:0]   byte_val;
   logic                          have_byte;
   logic                          text_idle;

   always_comb begin
      sx          = sb64_pkg::sextet_of(in_char);
      is_pad      = (in_char == sb64_pkg::CHAR_PAD);
      prev_in     = prev_ff;
      pads_in     = pads_ff;
      hard_in     = hard_ff;
      noncanon_in = noncanon_ff;
      have_byte   = 1'b0;
      byte_val    = '0;
      pos_in      = pos_ff + sb64_pkg::POS_W'(1);
      seen_in     = 1'b1;

      case (pos_ff)
         sb64_pkg::POS_TWO:   mask = sb64_pkg::TAIL_MASK_POS2;
         sb64_pkg::POS_THREE: mask = sb64_pkg::TAIL_MASK_POS3;
         default:             mask = '0;
      endcase

      if (is_pad) begin
         if (pads_ff == sb64_pkg::PADS_NONE) begin
            noncanon_in = |(prev_ff & mask);
         end
         if (pads_ff != sb64_pkg::PADS_MAX) begin
            pads_in = pads_ff + sb64_pkg::PADS_W'(1);
         end
      end else begin
         if (!sx.is_alpha || pads_ff != sb64_pkg::PADS_NONE) begin
            hard_in = 1'b1;
         end
         if (sx.is_alpha) begin
            prev_in = sx.value;
            case (pos_ff)
               sb64_pkg::POS_ONE: begin
                  byte_val  = {prev_ff, sx.value[5:4]};
                  have_byte = 1'b1;
               end
               sb64_pkg::POS_TWO: begin
                  byte_val  = {prev_ff[3:0], sx.value[5:2]};
                  have_byte = 1'b1;
               end
               sb64_pkg::POS_THREE: begin
                  byte_val  = {prev_ff[1:0], sx.value};
                  have_byte = 1'b1;
               end
               default: begin
                  have_byte = 1'b0;
               end
            endcase
         end
      end

      result.emit       = have_byte || is_final;
      result.out_byte   = byte_val;
      result.byte_valid = have_byte;
      result.done_res   = is_final;
      result.status     = sb64_pkg::STATUS_OK;
      if (is_final) begin
         if (hard_in || pads_in == sb64_pkg::PADS_MAX ||
             (pads_in != sb64_pkg::PADS_NONE && !seen_ff)) begin
            result.status = sb64_pkg::STATUS_INVALID;
         end else if (pos_in != sb64_pkg::POS_ZERO) begin
            result.status = sb64_pkg::STATUS_MISSING_PAD;
         end else if (pads_in != sb64_pkg::PADS_NONE && noncanon_in) begin
            result.status = sb64_pkg::STATUS_INVALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && is_final)) begin
         prev_ff     <= '0;
         pos_ff      <= sb64_pkg::POS_ZERO;
         pads_ff     <= sb64_pkg::PADS_NONE;
         seen_ff     <= 1'b0;
         hard_ff     <= 1'b0;
         noncanon_ff <= 1'b0;
      end else if (fire) begin
         prev_ff     <= prev_in;
         pos_ff      <= pos_in;
         pads_ff     <= pads_in;
         seen_ff     <= seen_in;
         hard_ff     <= hard_in;
         noncanon_ff <= noncanon_in;
      end
   end

   assign text_idle = (pos_ff == sb64_pkg::POS_ZERO) && (pads_ff == sb64_pkg::PADS_NONE);

   `SB64_ASSERT_NEXT(a_clear_after_final, fire && is_final, text_idle && !seen_ff && !hard_ff)
   `SB64_ASSERT_IMPLIES(a_no_byte_at_pos0, result.byte_valid, pos_ff != sb64_pkg::POS_ZERO)
   `SB64_ASSERT_IMPLIES(a_seen_tracks_pos, !seen_ff, text_idle)

endmodule

// File: src/strict_base64_decoder_core.sv
// Top level: strict base64 decoder, one character per transaction, result register.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_in_char[8], req_is_final
//   rsp      out        rsp_valid/rsp_stall  rsp_out_byte[8], rsp_byte_valid,
//                                            rsp_status[2], rsp_done_res
//
// One character per cycle sustained unless rsp_stall holds the output register.
// Input register, combinational decode logic, output register.
// Characters that decode no byte and are not final produce no rsp transaction.
// Reset is synchronous and clears the text state; rsp_stall backs up into req_stall.
`include "assert_macros.svh"
module strict_base64_decoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sb64_pkg::CHAR_W-1:0] req_in_char,
   input  logic                        req_is_final,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sb64_pkg::CHAR_W-1:0] rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_done_res
);

   logic                        item_valid;
   logic [sb64_pkg::CHAR_W-1:0] item_char;
   logic                        item_final;
   logic                        out_open;
   logic                        advance;
   sb64_pkg::result_type        result;

   logic                        rsp_valid_ff, rsp_valid_in;
   sb64_pkg::result_type        rsp_ff;

   assign out_open = !rsp_valid_ff || !rsp_stall;
   assign advance  = item_valid && out_open;

   sb64_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_char  (req_in_char),
      .req_is_final (req_is_final),
      .advance      (advance),
      .item_valid   (item_valid),
      .item_char    (item_char),
      .item_final   (item_final)
   );

   sb64_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .in_char  (item_char),
      .is_final (item_final),
      .result   (result)
   );

   assign rsp_valid_in = out_open ? (advance && result.emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && result.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_byte_valid = rsp_ff.byte_valid;
   assign rsp_status     = rsp_ff.status;
   assign rsp_done_res   = rsp_ff.done_res;

   `SB64_ASSERT_IMPLIES(a_stall_needs_backup, req_stall, rsp_valid_ff && rsp_stall && item_valid)
   `SB64_ASSERT_IMPLIES(a_rsp_has_content, rsp_valid_ff, rsp_ff.byte_valid || rsp_ff.done_res)
   `SB64_ASSERT_IMPLIES(a_status_only_final, rsp_valid && !rsp_done_res, rsp_status == 2'd0)

endmodule
